/* hw/rtl/tno_pkg.sv */
package tno_pkg;

    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_SE   = 8'd240;
    localparam logic [7:0] CODE_SEND = 8'd1;
    localparam logic [7:0] CODE_IS   = 8'd0;
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;

    localparam int QUEUE_DEPTH = 4;

    // what the back end has to produce for one command
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_PLAIN = 2'd1,
        KIND_SUB   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] first;   // data byte, or answer verb of a plain reply
        logic [7:0] option;
    } t_cmd;

    function automatic logic option_known(input logic [7:0] opt);
        option_known = (opt == OPT_ECHO) || (opt == OPT_SGA);
    endfunction

endpackage

/* hw/rtl/tno_front.sv */
module tno_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_op,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output tno_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        PH_IAC    = 2'd0,
        PH_VERB   = 2'd1,
        PH_SUB    = 2'd2,
        PH_OPTION = 2'd3
    } t_phase;

    logic       r_negotiating, n_negotiating;
    t_phase     r_phase, n_phase;
    logic [7:0] r_verb, n_verb;
    logic [7:0] r_option, n_option;
    logic [7:0] r_modifier, n_modifier;
    logic [1:0] r_subpos, n_subpos;

    always_comb begin
        n_negotiating = r_negotiating;
        n_phase       = r_phase;
        n_verb        = r_verb;
        n_option      = r_option;
        n_modifier    = r_modifier;
        n_subpos      = r_subpos;
        o_push        = 1'b0;
        o_cmd.kind    = tno_pkg::KIND_DATA;
        o_cmd.first   = i_rx_byte;
        o_cmd.option  = i_rx_byte;
        if (i_accept) begin
            if (i_op) begin
                n_negotiating = 1'b1;
                n_phase       = PH_IAC;
                n_verb        = 8'd0;
                n_option      = 8'd0;
                n_modifier    = 8'd0;
                n_subpos      = 2'd0;
            end else if (!r_negotiating) begin
                o_push = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_IAC: begin
                        if (i_rx_byte == tno_pkg::CODE_IAC) begin
                            n_phase = PH_VERB;
                        end else begin
                            n_negotiating = 1'b0;
                            o_push        = 1'b1;
                        end
                    end
                    PH_VERB: begin
                        n_verb = i_rx_byte;
                        if (i_rx_byte == tno_pkg::CODE_SB) begin
                            n_phase    = PH_SUB;
                            n_subpos   = 2'd0;
                            n_option   = 8'd0;
                            n_modifier = 8'd0;
                        end else begin
                            n_phase = PH_OPTION;
                        end
                    end
                    PH_SUB: begin
                        if (i_rx_byte == tno_pkg::CODE_SE) begin
                            n_phase      = PH_IAC;
                            o_cmd.kind   = tno_pkg::KIND_SUB;
                            o_cmd.option = r_option;
                            o_push       = (r_subpos >= 2'd2)
                                && tno_pkg::option_known(r_option)
                                && (r_modifier == tno_pkg::CODE_SEND);
                        end else begin
                            if (r_subpos == 2'd0) begin
                                n_option = i_rx_byte;
                            end else if (r_subpos == 2'd1) begin
                                n_modifier = i_rx_byte;
                            end
                            if (r_subpos != 2'd3) begin
                                n_subpos = r_subpos + 2'd1;
                            end
                        end
                    end
                    PH_OPTION: begin
                        n_option   = i_rx_byte;
                        n_phase    = PH_IAC;
                        o_cmd.kind = tno_pkg::KIND_PLAIN;
                        o_push     = 1'b1;
                        unique case (r_verb)
                            tno_pkg::CODE_DO:
                                o_cmd.first = tno_pkg::option_known(i_rx_byte)
                                    ? tno_pkg::CODE_WILL : tno_pkg::CODE_WONT;
                            tno_pkg::CODE_DONT:
                                o_cmd.first = tno_pkg::CODE_WONT;
                            tno_pkg::CODE_WILL:
                                o_cmd.first = tno_pkg::option_known(i_rx_byte)
                                    ? tno_pkg::CODE_DO : tno_pkg::CODE_DONT;
                            tno_pkg::CODE_WONT:
                                o_cmd.first = tno_pkg::CODE_DONT;
                            default:
                                o_push = 1'b0;
                        endcase
                    end
                    default: n_phase = PH_IAC;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_negotiating <= 1'b1;
            r_phase       <= PH_IAC;
            r_verb        <= 8'd0;
            r_option      <= 8'd0;
            r_modifier    <= 8'd0;
            r_subpos      <= 2'd0;
        end else begin
            r_negotiating <= n_negotiating;
            r_phase       <= n_phase;
            r_verb        <= n_verb;
            r_option      <= n_option;
            r_modifier    <= n_modifier;
            r_subpos      <= n_subpos;
        end
    end

endmodule

/* hw/rtl/tno_queue.sv */
module tno_queue #(
    parameter int DEPTH = tno_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  tno_pkg::t_cmd              i_cmd,
    input  logic                       i_pop,
    output logic                       o_full,
    output logic                       o_empty,
    output tno_pkg::t_cmd              o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tno_pkg::t_cmd r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/tno_back.sv */
module tno_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  tno_pkg::t_cmd i_head,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_is_reply,
    output logic          o_last
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, sel_byte;
    logic       r_reply, sel_reply;
    logic       r_last, sel_last;
    logic       load;

    assign load = !i_empty && (!r_valid || !i_stall);

    // pick the byte of the head command at the current position
    always_comb begin
        sel_byte  = i_head.first;
        sel_reply = 1'b1;
        sel_last  = 1'b0;
        case (i_head.kind)
            tno_pkg::KIND_PLAIN: begin
                sel_last = (r_idx == 3'd2);
                case (r_idx)
                    3'd0:    sel_byte = tno_pkg::CODE_IAC;
                    3'd1:    sel_byte = i_head.first;
                    default: sel_byte = i_head.option;
                endcase
            end
            tno_pkg::KIND_SUB: begin
                sel_last = (r_idx == 3'd5);
                case (r_idx)
                    3'd0:    sel_byte = tno_pkg::CODE_IAC;
                    3'd1:    sel_byte = tno_pkg::CODE_SB;
                    3'd2:    sel_byte = i_head.option;
                    3'd3:    sel_byte = tno_pkg::CODE_IS;
                    3'd4:    sel_byte = tno_pkg::CODE_IAC;
                    default: sel_byte = tno_pkg::CODE_SE;
                endcase
            end
            default: begin
                sel_reply = 1'b0;
                sel_last  = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (sel_last) begin
                o_pop = 1'b1;
                n_idx = 3'd0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= sel_byte;
            r_reply <= sel_reply;
            r_last  <= sel_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_is_reply = r_reply;
    assign o_last     = r_last;

endmodule

/* hw/rtl/telnet_option_negotiator.sv */
// Telnet option negotiator.
// Input channel (i_valid / o_stall): one transaction per cycle carries i_op and
// i_rx_byte. i_op high restarts negotiation and gives no output. While
// negotiating, bytes are parsed as IAC verb option or IAC SB ... SE commands;
// each answered command produces its reply bytes (3 for a plain command, 6
// for an answered SB SEND). The first byte that does not start a command
// ends negotiation and it, and every later byte, pass through as data.
// Output channel (o_valid / i_stall): one byte per transaction; o_is_reply
// marks reply bytes and o_last closes the bytes caused by one input.
// Each command or data byte is written into a DEPTH-entry queue, and the
// expander loads the output register from the queue head. Throughput: one
// input per cycle while o_stall is low and one output byte per cycle while
// i_stall is low; o_stall rises only when the queue is full (replies held
// up by i_stall, or a long run of answered subnegotiations, which give six
// bytes for every five received). Reset clears the parser to negotiating,
// empties the queue and drops o_valid. Under i_stall the output register
// holds its byte.
module telnet_option_negotiator #(
    parameter int DEPTH = tno_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_reply,
    output logic       o_last
);

    logic                       accept;
    logic                       push, pop;
    logic                       full, empty;
    tno_pkg::t_cmd              cmd, head;
    logic [$clog2(DEPTH+1)-1:0] count;

    // accept whenever the queue has room
    assign o_stall = full;
    assign accept  = i_valid && !full;

    tno_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_op      (i_op),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_cmd     (cmd)
    );

    tno_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head),
        .o_count (count)
    );

    tno_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_is_reply (o_is_reply),
        .o_last     (o_last)
    );

    // queue occupancy stays within its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= ($clog2(DEPTH+1))'(DEPTH))
        else $error("queue count exceeds depth");

    // front never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("push while queue full");

    // a passed-through data byte is always a single-byte transaction group
    a_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_reply) |-> o_last)
        else $error("data byte without last");

    // a pop only happens while the queue holds an entry
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

    // Give up after this many cycles without a single transaction on either
    // channel. The longest legal quiet stretch is the deliberate receiver hold
    // (HOLD_CYCLES) plus reset.
    localparam int HOLD_CYCLES  = 100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 8;
    localparam int RANDOM_CHUNK = 105;

    // Parser position of the negotiator, kept by the predictor
    typedef enum logic [1:0] {
        PH_WAIT_IAC  = 2'd0,
        PH_WAIT_VERB = 2'd1,
        PH_IN_SUB    = 2'd2,
        PH_WAIT_OPT  = 2'd3
    } t_parse_phase;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // One byte on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       reply;
        logic       last;
    } t_tx_beat;

    // One row of the directed table. With fixed set, the expected bytes are
    // written out here; otherwise the predictor supplies them.
    typedef struct packed {
        logic            op;
        logic [7:0]      rx;
        logic            fixed;
        logic [2:0]      n_want;
        logic            want_reply;
        logic [0:5][7:0] want;
    } t_stim_row;

    localparam logic [47:0] NO_BYTES = 48'h0;
    localparam int N_DIRECTED = 24;

    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // right after reset: DO echo is agreed to
        '{OP_BYTE, tno_pkg::CODE_IAC,  1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_DO,   1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::OPT_ECHO,  1'b1, 3'd3, 1'b1,
          {tno_pkg::CODE_IAC, tno_pkg::CODE_WILL, tno_pkg::OPT_ECHO, 24'h0}},
        // WILL suppress go-ahead is agreed to
        '{OP_BYTE, tno_pkg::CODE_IAC,  1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_WILL, 1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::OPT_SGA,   1'b1, 3'd3, 1'b1,
          {tno_pkg::CODE_IAC, tno_pkg::CODE_DO, tno_pkg::OPT_SGA, 24'h0}},
        // WONT on the top option value is mirrored as DONT
        '{OP_BYTE, tno_pkg::CODE_IAC,  1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_WONT, 1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, 8'hFF,              1'b1, 3'd3, 1'b1,
          {tno_pkg::CODE_IAC, tno_pkg::CODE_DONT, 8'hFF, 24'h0}},
        // IAC IAC is an unknown verb: swallow the next byte, no reply
        '{OP_BYTE, tno_pkg::CODE_IAC,  1'b0, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_IAC,  1'b0, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, 8'h05,              1'b0, 3'd0, 1'b0, NO_BYTES},
        // SB SGA SEND SE is answered with IS
        '{OP_BYTE, tno_pkg::CODE_IAC,  1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_SB,   1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::OPT_SGA,   1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_SEND, 1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_SE,   1'b1, 3'd6, 1'b1,
          {tno_pkg::CODE_IAC, tno_pkg::CODE_SB, tno_pkg::OPT_SGA,
           tno_pkg::CODE_IS, tno_pkg::CODE_IAC, tno_pkg::CODE_SE}},
        // empty subnegotiation: no option seen, no reply
        '{OP_BYTE, tno_pkg::CODE_IAC,  1'b0, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_SB,   1'b0, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, tno_pkg::CODE_SE,   1'b0, 3'd0, 1'b0, NO_BYTES},
        // restart, then a non-IAC byte ends negotiation and passes through
        '{OP_RESTART, 8'hFF,  1'b1, 3'd0, 1'b0, NO_BYTES},
        '{OP_BYTE, 8'h00,     1'b1, 3'd1, 1'b0, {8'h00, 40'h0}},
        // once in data mode even IAC passes through
        '{OP_BYTE, 8'hFF,     1'b1, 3'd1, 1'b0, {8'hFF, 40'h0}},
        '{OP_RESTART, 8'h00,  1'b1, 3'd0, 1'b0, NO_BYTES}
    };

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       i_op      = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_is_reply;
    logic       o_last;

    telnet_option_negotiator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_is_reply (o_is_reply),
        .o_last     (o_last)
    );

    // Predictor state: mirror of the negotiator's parser
    logic         neg_on    = 1'b1;
    t_parse_phase phase     = PH_WAIT_IAC;
    logic [7:0]   held_verb = 8'h00;
    logic [7:0]   held_opt  = 8'h00;
    logic [7:0]   held_mod  = 8'h00;
    logic [1:0]   sub_cnt   = 2'd0;

    t_tx_beat step_beats[$];   // bytes caused by the transaction just accepted
    t_tx_beat awaited[$];      // bytes still owed by the block, oldest first

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int quiet_cycles = 0;

    int errors        = 0;
    int items_sent    = 0;
    int restarts_sent = 0;
    int reply_beats   = 0;
    int data_beats    = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void add_beat(input logic [7:0] d, input logic r);
        step_beats.push_back('{data: d, reply: r, last: 1'b0});
    endfunction

    // Advance the predictor by one accepted input transaction and leave the
    // bytes it causes in step_beats.
    task automatic predict_step(input logic op, input logic [7:0] b);
        logic       agreed;
        logic [7:0] answer;
        step_beats.delete();
        if (op == OP_RESTART) begin
            neg_on    = 1'b1;
            phase     = PH_WAIT_IAC;
            held_verb = 8'h00;
            held_opt  = 8'h00;
            held_mod  = 8'h00;
            sub_cnt   = 2'd0;
        end else if (!neg_on) begin
            add_beat(b, 1'b0);
        end else begin
            case (phase)
                PH_WAIT_IAC: begin
                    if (b == tno_pkg::CODE_IAC) begin
                        phase = PH_WAIT_VERB;
                    end else begin
                        // first stray byte drops out of negotiation
                        neg_on = 1'b0;
                        add_beat(b, 1'b0);
                    end
                end
                PH_WAIT_VERB: begin
                    held_verb = b;
                    if (b == tno_pkg::CODE_SB) begin
                        phase    = PH_IN_SUB;
                        sub_cnt  = 2'd0;
                        held_opt = 8'h00;
                        held_mod = 8'h00;
                    end else begin
                        phase = PH_WAIT_OPT;
                    end
                end
                PH_IN_SUB: begin
                    if (b == tno_pkg::CODE_SE) begin
                        agreed = (held_opt == tno_pkg::OPT_ECHO)
                            || (held_opt == tno_pkg::OPT_SGA);
                        if (sub_cnt >= 2'd2 && agreed && held_mod == tno_pkg::CODE_SEND) begin
                            add_beat(tno_pkg::CODE_IAC, 1'b1);
                            add_beat(tno_pkg::CODE_SB, 1'b1);
                            add_beat(held_opt, 1'b1);
                            add_beat(tno_pkg::CODE_IS, 1'b1);
                            add_beat(tno_pkg::CODE_IAC, 1'b1);
                            add_beat(tno_pkg::CODE_SE, 1'b1);
                        end
                        phase = PH_WAIT_IAC;
                    end else begin
                        if (sub_cnt == 2'd0) held_opt = b;
                        else if (sub_cnt == 2'd1) held_mod = b;
                        if (sub_cnt != 2'd3) sub_cnt = sub_cnt + 2'd1;
                    end
                end
                default: begin
                    held_opt = b;
                    agreed   = (b == tno_pkg::OPT_ECHO) || (b == tno_pkg::OPT_SGA);
                    answer   = 8'h00;
                    case (held_verb)
                        tno_pkg::CODE_DO:
                            answer = agreed ? tno_pkg::CODE_WILL : tno_pkg::CODE_WONT;
                        tno_pkg::CODE_DONT:
                            answer = tno_pkg::CODE_WONT;
                        tno_pkg::CODE_WILL:
                            answer = agreed ? tno_pkg::CODE_DO : tno_pkg::CODE_DONT;
                        tno_pkg::CODE_WONT:
                            answer = tno_pkg::CODE_DONT;
                        default:
                            answer = 8'h00;
                    endcase
                    // unknown verbs swallow their option and stay silent
                    if (answer != 8'h00) begin
                        add_beat(tno_pkg::CODE_IAC, 1'b1);
                        add_beat(answer, 1'b1);
                        add_beat(held_opt, 1'b1);
                    end
                    phase = PH_WAIT_IAC;
                end
            endcase
        end
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    endtask

    // Offer one transaction, hold it through o_stall, then predict it.
    // With use_model clear the caller queues fixed expectations instead.
    task automatic send_item(input logic op, input logic [7:0] b, input bit use_model);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (op == OP_RESTART) restarts_sent++;
        predict_step(op, b);
        if (use_model) begin
            foreach (step_beats[k]) awaited.push_back(step_beats[k]);
        end
    endtask

    // Drop valid and wait until every owed byte has been taken. Always spend
    // at least one edge so valid is never lowered and raised in one step.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited.size() != 0);
    endtask

    function automatic logic [7:0] rand_not_se();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == tno_pkg::CODE_SE) b = b ^ 8'h01;
        return b;
    endfunction

    function automatic logic [7:0] pick_option();
        case ($urandom_range(0, 3))
            0:       return tno_pkg::OPT_ECHO;
            1:       return tno_pkg::OPT_SGA;
            default: return rand_not_se();
        endcase
    endfunction

    // One random unit: mostly well-formed commands with random content,
    // plus restarts, stray bytes and cut-short subnegotiations.
    task automatic send_random_unit();
        int         pick;
        int         nbody;
        logic [7:0] verb;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (!neg_on) begin
            // in data mode: either restart parsing or pass one to three bytes
            if (pick < 45) begin
                send_item(OP_RESTART, 8'($urandom_range(0, 255)), 1'b1);
            end else begin
                repeat ($urandom_range(1, 3))
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            end
        end else if (pick < 45) begin
            case ($urandom_range(0, 9))
                0, 1:    verb = tno_pkg::CODE_DO;
                2, 3:    verb = tno_pkg::CODE_DONT;
                4, 5:    verb = tno_pkg::CODE_WILL;
                6, 7:    verb = tno_pkg::CODE_WONT;
                8:       verb = tno_pkg::CODE_IAC;
                default: verb = 8'($urandom_range(0, 255));
            endcase
            send_item(OP_BYTE, tno_pkg::CODE_IAC, 1'b1);
            send_item(OP_BYTE, verb, 1'b1);
            send_item(OP_BYTE, pick_option(), 1'b1);
        end else if (pick < 70) begin
            send_item(OP_BYTE, tno_pkg::CODE_IAC, 1'b1);
            send_item(OP_BYTE, tno_pkg::CODE_SB, 1'b1);
            nbody = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 1)
                                                  : $urandom_range(2, 4);
            for (int k = 0; k < nbody; k++) begin
                if (k == 0) b = pick_option();
                else if (k == 1) b = ($urandom_range(0, 99) < 70) ? tno_pkg::CODE_SEND
                                                                 : rand_not_se();
                else b = rand_not_se();
                send_item(OP_BYTE, b, 1'b1);
            end
            send_item(OP_BYTE, tno_pkg::CODE_SE, 1'b1);
        end else if (pick < 78) begin
            send_item(OP_RESTART, 8'($urandom_range(0, 255)), 1'b1);
        end else if (pick < 92) begin
            // noise: any byte, may break into the middle of a command
            send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
        end else begin
            b = 8'($urandom_range(0, 254));
            send_item(OP_BYTE, b, 1'b1);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_random_unit();
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Output side: check every accepted byte against the oldest expectation,
    // then pick the next stall value. A requested hold is counted out here.
    always @(posedge i_clk) begin : out_monitor
        t_tx_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited.size() == 0) begin
                $display("%0t: unexpected output, expected none,", $time,
                         " actual byte %0d reply %0b last %0b",
                         o_out_byte, o_is_reply, o_last);
                errors++;
            end else begin
                want = awaited.pop_front();
                check_field("out_byte", want.data, o_out_byte);
                check_field("is_reply", {7'd0, want.reply}, {7'd0, o_is_reply});
                check_field("last", {7'd0, want.last}, {7'd0, o_last});
            end
            if (o_is_reply) reply_beats++;
            else data_beats++;
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Count cycles in which neither channel completes a transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles, %0d bytes still owed",
                 $time, QUIET_LIMIT, awaited.size());
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling on either side
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(DIRECTED[r].op, DIRECTED[r].rx, !DIRECTED[r].fixed);
            if (DIRECTED[r].fixed) begin
                for (int k = 0; k < int'(DIRECTED[r].n_want); k++)
                    awaited.push_back('{data:  DIRECTED[r].want[k],
                                        reply: DIRECTED[r].want_reply,
                                        last:  (k == int'(DIRECTED[r].n_want) - 1)});
            end
        end
        wait_drained();

        // sender idles less than the receiver
        tx_idle_pct = 28;
        rx_idle_pct = 57;
        run_random(RANDOM_CHUNK);
        wait_drained();

        // and the other way round
        tx_idle_pct = 57;
        rx_idle_pct = 28;
        run_random(RANDOM_CHUNK);
        wait_drained();

        // back-pressure: hold the output while answered commands keep coming,
        // so the command queue fills and the block stalls its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        repeat (10) begin
            send_item(OP_BYTE, tno_pkg::CODE_IAC, 1'b1);
            case ($urandom_range(0, 3))
                0:       send_item(OP_BYTE, tno_pkg::CODE_DO, 1'b1);
                1:       send_item(OP_BYTE, tno_pkg::CODE_DONT, 1'b1);
                2:       send_item(OP_BYTE, tno_pkg::CODE_WILL, 1'b1);
                default: send_item(OP_BYTE, tno_pkg::CODE_WONT, 1'b1);
            endcase
            send_item(OP_BYTE, ($urandom_range(0, 1) != 0) ? tno_pkg::OPT_ECHO
                                                           : tno_pkg::OPT_SGA, 1'b1);
        end
        wait_drained();

        // full rate on both sides
        run_random(RANDOM_CHUNK);
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Run covered %0d input transactions (%0d restarts) under three idling mixes",
                 items_sent, restarts_sent);
        $display("and one long output hold; checked %0d reply bytes and %0d data bytes",
                 reply_beats, data_beats);
        if (errors == 0 && awaited.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* telnet_option_negotiator.f */
hw/rtl/tno_pkg.sv
hw/rtl/tno_front.sv
hw/rtl/tno_queue.sv
hw/rtl/tno_back.sv
hw/rtl/telnet_option_negotiator.sv
sim/tb.sv
